### sv/frc_pkg.sv
// shared types and constants for the uart receive frame collector
package frc_pkg;

   // default buffer depth
   localparam int MaxFrameDefault = 256;

   // register reset values and widths
   localparam int MaxLenW         = 9;
   localparam int TimeoutW        = 8;
   localparam logic [8:0] MaxLenReset  = 9'd256;
   localparam logic [7:0] TimeoutReset = 8'd7;
   localparam logic [7:0] TickSat      = 8'hFF;

   // configuration register indexes
   localparam logic [1:0] CsrMaxFrameLen = 2'd0;
   localparam logic [1:0] CsrIdleTimeout = 2'd1;

   // line status bits
   localparam int LsParity    = 0;
   localparam int LsFraming   = 1;
   localparam int LsOverrun   = 2;
   localparam int LsCollision = 5;

   typedef enum logic [2:0] {
      OP_ARM     = 3'd0,
      OP_BYTE    = 3'd1,
      OP_TICK    = 3'd2,
      OP_ABORT   = 3'd3,
      OP_COLLECT = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_ACTIVE = 2'd2,
      MODE_DONE   = 2'd3
   } rx_mode_type;

   typedef struct packed {
      logic collision;
      logic overflow;
      logic brk;
      logic framing;
      logic parity;
   } err_flags_type;

   typedef struct packed {
      logic [8:0] max_frame_len;
      logic [7:0] idle_timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] rx_byte;
      logic [5:0] line_status;
   } req_item_type;

   typedef struct packed {
      logic          busy_res;
      err_flags_type errs;
      logic [8:0]    byte_count;
      logic          frame_done;
      logic [7:0]    write_data;
      logic [7:0]    write_address;
      logic          write_enable;
      logic          accepted;
   } rsp_item_type;

endpackage

### sv/frc_csr.sv
// configuration registers for frame length and idle timeout
module frc_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [8:0]       csr_data,
   output frc_pkg::cfg_type cfg
);
   import frc_pkg::*;

   logic [8:0] max_len_ff, max_len_in;
   logic [7:0] timeout_ff, timeout_in;

   assign csr_ready = 1'b1;

   // register write decode
   always_comb begin
      max_len_in = max_len_ff;
      timeout_in = timeout_ff;
      if (csr_valid) begin
         case (csr_index)
            CsrMaxFrameLen: max_len_in = csr_data;
            CsrIdleTimeout: timeout_in = csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MaxLenReset;
         timeout_ff <= TimeoutReset;
      end else begin
         max_len_ff <= max_len_in;
         timeout_ff <= timeout_in;
      end
   end

   assign cfg.max_frame_len      = max_len_ff;
   assign cfg.idle_timeout_ticks = timeout_ff;

endmodule

### sv/frc_in_reg.sv
// input register stage for request beats
module frc_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  frc_pkg::req_item_type req_item,
   input  logic                  advance,
   output logic                  item_valid,
   output frc_pkg::req_item_type item
);
   import frc_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff;

   // room when empty or when the held beat moves on this cycle
   assign req_tready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### sv/frc_engine.sv
// receiver state, per-beat update and result register
module frc_engine #(
   parameter int MAX_FRAME = frc_pkg::MaxFrameDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  frc_pkg::cfg_type      cfg,
   input  logic                  item_valid,
   input  frc_pkg::req_item_type item,
   output logic                  advance,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output frc_pkg::rsp_item_type rsp_item
);
   import frc_pkg::*;

   localparam int LimMax = (MAX_FRAME < 511) ? MAX_FRAME : 511;
   localparam int CntW   = $clog2(LimMax + 1);

   rx_mode_type   mode_ff, mode_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [CntW-1:0] limit_ff, limit_in;
   logic [7:0]    ticks_ff, ticks_in;
   err_flags_type errs_ff, errs_in;
   logic          out_valid_ff, out_valid_in;
   rsp_item_type  res_ff, res_in;

   opcode_type      op;
   logic [CntW-1:0] cnt_inc;
   logic [7:0]      tick_inc;
   logic [8:0]      cnt_wide;

   assign op       = opcode_type'(item.opcode);
   assign cnt_inc  = cnt_ff + 1'b1;
   assign tick_inc = (ticks_ff < TickSat) ? ticks_ff + 8'd1 : ticks_ff;
   assign cnt_wide = 9'(cnt_ff);

   // a beat moves on when the result register is free
   assign advance = item_valid && (!out_valid_ff || rsp_tready);

   // next state
   always_comb begin
      mode_in  = mode_ff;
      cnt_in   = cnt_ff;
      limit_in = limit_ff;
      ticks_in = ticks_ff;
      errs_in  = errs_ff;
      case (op)
         OP_ARM: begin
            if (mode_ff == MODE_IDLE && cfg.max_frame_len != '0) begin
               cnt_in   = '0;
               errs_in  = '0;
               ticks_in = '0;
               mode_in  = MODE_ACTIVE;
               if (32'(cfg.max_frame_len) < MAX_FRAME) begin
                  limit_in = CntW'(cfg.max_frame_len);
               end else begin
                  limit_in = CntW'(MAX_FRAME);
               end
            end
         end
         OP_BYTE: begin
            if (mode_ff == MODE_ACTIVE) begin
               if (cnt_ff >= limit_ff) begin
                  errs_in.overflow = 1'b1;
               end else begin
                  errs_in.parity    = errs_ff.parity | item.line_status[LsParity];
                  errs_in.framing   = errs_ff.framing | item.line_status[LsFraming];
                  errs_in.brk       = errs_ff.brk
                                      | (item.line_status[LsFraming] && item.rx_byte == '0);
                  errs_in.overflow  = errs_ff.overflow | item.line_status[LsOverrun];
                  errs_in.collision = errs_ff.collision | item.line_status[LsCollision];
                  cnt_in   = cnt_inc;
                  ticks_in = '0;
                  if (cnt_inc >= limit_ff) begin
                     mode_in = MODE_DONE;
                  end
               end
            end
         end
         OP_TICK: begin
            if (mode_ff == MODE_ACTIVE && cnt_ff != '0) begin
               ticks_in = tick_inc;
               if (tick_inc >= cfg.idle_timeout_ticks) begin
                  mode_in = MODE_DONE;
               end
            end
         end
         OP_ABORT: begin
            cnt_in  = '0;
            errs_in = '0;
            mode_in = MODE_IDLE;
         end
         OP_COLLECT: begin
            if (mode_ff == MODE_DONE) begin
               cnt_in  = '0;
               errs_in = '0;
               mode_in = MODE_IDLE;
            end
         end
         default: ;
      endcase
   end

   // result fields
   always_comb begin
      res_in            = '0;
      res_in.frame_done = (mode_in == MODE_DONE);
      res_in.busy_res   = (mode_in != MODE_IDLE);
      case (op)
         OP_ARM: begin
            res_in.accepted = (mode_ff == MODE_IDLE);
         end
         OP_BYTE: begin
            if (mode_ff == MODE_ACTIVE && cnt_ff < limit_ff) begin
               res_in.write_enable  = 1'b1;
               res_in.write_address = cnt_wide[7:0];
               res_in.write_data    = item.rx_byte;
            end
         end
         OP_COLLECT: begin
            if (mode_ff == MODE_DONE) begin
               res_in.accepted   = 1'b1;
               res_in.byte_count = cnt_wide;
               res_in.errs       = errs_ff;
            end
         end
         default: ;
      endcase
   end

   // output valid tracking
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         cnt_ff       <= '0;
         limit_ff     <= CntW'(LimMax);
         ticks_ff     <= '0;
         errs_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            mode_ff  <= mode_in;
            cnt_ff   <= cnt_in;
            limit_ff <= limit_in;
            ticks_ff <= ticks_in;
            errs_ff  <= errs_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   // result payload, no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_item   = res_ff;

endmodule

### sv/uart_rx_frame_collector_timeout_top.sv
// Top level of the uart receive frame collector with idle timeout.
// An accepted request beat goes through the input register, then the result
// register, to its response beat.
// Throughput: one beat per cycle unless rsp_tready holds the result register; the state
// update is a single pass of logic between the two registers.
// Reset: synchronous, active high; receiver idle, counters and flags clear.
module uart_rx_frame_collector_timeout_top #(
   parameter int MAX_FRAME = frc_pkg::MaxFrameDefault
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // rx_byte[7:0], line_status[13:8], zero[15:14]
   input  logic [2:0]  req_tuser,   // opcode[2:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // accepted[0], write_enable[1], write_address[9:2],
                                    // write_data[17:10], frame_done[18], byte_count[27:19],
                                    // parity_flag[28], framing_flag[29], break_flag[30],
                                    // overflow_flag[31], collision_flag[32], busy_res[33],
                                    // zero[39:34]
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_data
);
   import frc_pkg::*;

   cfg_type      cfg;
   req_item_type req_item;
   req_item_type item;
   rsp_item_type rsp_item;
   logic         item_valid;
   logic         advance;

   assign req_item.opcode      = req_tuser;
   assign req_item.rx_byte     = req_tdata[7:0];
   assign req_item.line_status = req_tdata[13:8];

   frc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   frc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   frc_engine #(
      .MAX_FRAME (MAX_FRAME)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   // pack the response beat
   assign rsp_tdata = {
      6'd0,
      rsp_item.busy_res,
      rsp_item.errs.collision,
      rsp_item.errs.overflow,
      rsp_item.errs.brk,
      rsp_item.errs.framing,
      rsp_item.errs.parity,
      rsp_item.byte_count,
      rsp_item.frame_done,
      rsp_item.write_data,
      rsp_item.write_address,
      rsp_item.write_enable,
      rsp_item.accepted
   };

endmodule

### sim/tb_uart_rx_frame_collector_timeout_top.sv
// self-checking stream testbench for the uart receive frame collector with idle timeout
`timescale 1ns / 1ps

module tb_uart_rx_frame_collector_timeout_top;
   import frc_pkg::*;

   localparam int          FrameDepth  = MaxFrameDefault;
   localparam int          PipeLatency = 2;
   localparam int          ResetCycles = 12;
   localparam int          PhaseBeats  = 30;
   localparam int unsigned CycleLimit  = 400000;

   // csr index with no register behind it
   localparam logic [1:0] CsrUnmapped = 2'd3;
   // opcodes outside the defined set
   localparam logic [2:0] OpReservedLo = 3'd5;
   localparam logic [2:0] OpReservedHi = 3'd7;

   // status words that can be read straight off the behaviour
   localparam rsp_item_type RSP_IDLE      = 34'h0_0000_0000;
   localparam rsp_item_type RSP_BUSY      = 34'h2_0000_0000;
   localparam rsp_item_type RSP_ARMED     = 34'h2_0000_0001;
   localparam rsp_item_type RSP_ARM_EMPTY = 34'h0_0000_0001;

   typedef enum logic { ROW_BEAT, ROW_CSR } row_kind_type;

   typedef struct {
      row_kind_type kind;
      req_item_type beat;
      logic [1:0]   csr_idx;
      logic [8:0]   csr_val;
      bit           typed;
      rsp_item_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // rx_byte[7:0], line_status[13:8], zero[15:14]
   logic [2:0]  req_tuser = '0;    // opcode[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // accepted .. busy_res[33], zero[39:34]
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [8:0]  csr_data = '0;

   // collector state as the predictor sees it
   cfg_type       cfg_q         = '{max_frame_len: MaxLenReset, idle_timeout_ticks: TimeoutReset};
   rx_mode_type   rx_mode_q     = MODE_IDLE;
   logic [8:0]    rcv_count_q   = '0;
   logic [7:0]    idle_ticks_q  = '0;
   err_flags_type errs_q        = '0;
   logic [8:0]    frame_limit_q = 9'(FrameDepth);

   rsp_item_type  frame_status_q[$];
   stim_row_type  directed_rows[$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned beats_counted = 0;
   int unsigned fail_count    = 0;
   int unsigned cycle_count   = 0;

   uart_rx_frame_collector_timeout_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // advance the collector by one beat and return its status word
   function automatic rsp_item_type step_collector(input req_item_type it);
      rsp_item_type r;
      r = '0;
      case (it.opcode)
         OP_ARM: begin
            if (rx_mode_q == MODE_IDLE) begin
               r.accepted = 1'b1;
               // zero length is accepted but never arms
               if (cfg_q.max_frame_len != '0) begin
                  rcv_count_q   = '0;
                  errs_q        = '0;
                  idle_ticks_q  = '0;
                  frame_limit_q = (cfg_q.max_frame_len < FrameDepth) ?
                                  cfg_q.max_frame_len : 9'(FrameDepth);
                  rx_mode_q     = MODE_ACTIVE;
               end
            end
         end
         OP_BYTE: begin
            if (rx_mode_q == MODE_ACTIVE) begin
               if (rcv_count_q >= frame_limit_q) begin
                  errs_q.overflow = 1'b1;
               end else begin
                  // sticky line errors, break is framing on a null byte
                  if (it.line_status[LsParity]) errs_q.parity = 1'b1;
                  if (it.line_status[LsFraming]) begin
                     errs_q.framing = 1'b1;
                     if (it.rx_byte == 8'h00) errs_q.brk = 1'b1;
                  end
                  if (it.line_status[LsOverrun]) errs_q.overflow = 1'b1;
                  if (it.line_status[LsCollision]) errs_q.collision = 1'b1;
                  r.write_enable  = 1'b1;
                  r.write_address = rcv_count_q[7:0];
                  r.write_data    = it.rx_byte;
                  rcv_count_q     = rcv_count_q + 9'd1;
                  idle_ticks_q    = '0;
                  if (rcv_count_q >= frame_limit_q) rx_mode_q = MODE_DONE;
               end
            end
         end
         OP_TICK: begin
            // only counted once the first byte is in
            if (rx_mode_q == MODE_ACTIVE && rcv_count_q != '0) begin
               if (idle_ticks_q != TickSat) idle_ticks_q = idle_ticks_q + 8'd1;
               if (idle_ticks_q >= cfg_q.idle_timeout_ticks) rx_mode_q = MODE_DONE;
            end
         end
         OP_ABORT: begin
            rcv_count_q = '0;
            errs_q      = '0;
            rx_mode_q   = MODE_IDLE;
         end
         OP_COLLECT: begin
            if (rx_mode_q == MODE_DONE) begin
               r.accepted   = 1'b1;
               r.byte_count = rcv_count_q;
               r.errs       = errs_q;
               rcv_count_q  = '0;
               errs_q       = '0;
               rx_mode_q    = MODE_IDLE;
            end
         end
         default: ;
      endcase
      r.frame_done = (rx_mode_q == MODE_DONE);
      r.busy_res   = (rx_mode_q != MODE_IDLE);
      return r;
   endfunction

   function automatic void check_field(input string fname, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
         fail_count++;
      end
   endfunction

   // compare a result beat with the oldest predicted status
   function automatic void check_result(input rsp_item_type got);
      rsp_item_type want;
      if (frame_status_q.size() == 0) begin
         $error("result beat 0x%0h with nothing outstanding", got);
         fail_count++;
      end else begin
         want = frame_status_q.pop_front();
         check_field("accepted",       32'(want.accepted),       32'(got.accepted));
         check_field("write_enable",   32'(want.write_enable),   32'(got.write_enable));
         check_field("write_address",  32'(want.write_address),  32'(got.write_address));
         check_field("write_data",     32'(want.write_data),     32'(got.write_data));
         check_field("frame_done",     32'(want.frame_done),     32'(got.frame_done));
         check_field("byte_count",     32'(want.byte_count),     32'(got.byte_count));
         check_field("parity_flag",    32'(want.errs.parity),    32'(got.errs.parity));
         check_field("framing_flag",   32'(want.errs.framing),   32'(got.errs.framing));
         check_field("break_flag",     32'(want.errs.brk),       32'(got.errs.brk));
         check_field("overflow_flag",  32'(want.errs.overflow),  32'(got.errs.overflow));
         check_field("collision_flag", 32'(want.errs.collision), 32'(got.errs.collision));
         check_field("busy_res",       32'(want.busy_res),       32'(got.busy_res));
      end
   endfunction

   // result side: check on every accepted beat, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result(rsp_item_type'(rsp_tdata[33:0]));
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // drive one request beat, predict its status once it is taken
   task automatic send_req(input req_item_type it, input bit typed, input rsp_item_type want);
      rsp_item_type pred;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.opcode;
      req_tdata  <= {2'b00, it.line_status, it.rx_byte};
      do @(posedge clock); while (!req_tready);
      pred = step_collector(it);
      frame_status_q.push_back(typed ? want : pred);
      if (it.opcode <= OP_COLLECT) beats_counted++;
   endtask

   task automatic send_beat(input logic [2:0] op, input logic [7:0] rx, input logic [5:0] ls);
      req_item_type it;
      it.opcode      = op;
      it.rx_byte     = rx;
      it.line_status = ls;
      send_req(it, 1'b0, RSP_IDLE);
   endtask

   // hold off the sender until every outstanding status has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (frame_status_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [8:0] val);
      wait_drained();
      repeat (PipeLatency + 1) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CsrMaxFrameLen) cfg_q.max_frame_len = val;
      else if (idx == CsrIdleTimeout) cfg_q.idle_timeout_ticks = val[7:0];
   endtask

   function automatic stim_row_type beat_row(input logic [2:0] op, input logic [7:0] rx,
                                             input logic [5:0] ls, input bit typed,
                                             input rsp_item_type want);
      stim_row_type row;
      row.kind             = ROW_BEAT;
      row.beat.opcode      = op;
      row.beat.rx_byte     = rx;
      row.beat.line_status = ls;
      row.csr_idx          = '0;
      row.csr_val          = '0;
      row.typed            = typed;
      row.want             = want;
      return row;
   endfunction

   function automatic stim_row_type csr_row(input logic [1:0] idx, input logic [8:0] val);
      stim_row_type row;
      row       = beat_row(OP_ABORT, 8'h00, 6'h00, 1'b0, RSP_IDLE);
      row.kind  = ROW_CSR;
      row.csr_idx = idx;
      row.csr_val = val;
      return row;
   endfunction

   task automatic send_rx_byte();
      logic [7:0] rx;
      logic [5:0] ls;
      rx = ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
      ls = ($urandom_range(0, 2) == 0) ? 6'($urandom_range(0, 63)) : 6'h00;
      send_beat(OP_BYTE, rx, ls);
   endtask

   // one well-formed frame with random content, noisy unless asked to be clean
   task automatic run_frame(input int unsigned n_bytes, input bit clean);
      int unsigned k;
      int unsigned gap_max;
      // get the receiver back to idle first
      if (rx_mode_q == MODE_DONE && $urandom_range(0, 1) == 0)
         send_beat(OP_COLLECT, 8'($urandom), 6'($urandom));
      else if (rx_mode_q != MODE_IDLE)
         send_beat(OP_ABORT, 8'($urandom), 6'($urandom));
      send_beat(OP_ARM, 8'($urandom), 6'($urandom));
      if (!clean && $urandom_range(0, 7) == 0) send_beat(OP_ARM, 8'h00, 6'h00);
      if (!clean && $urandom_range(0, 5) == 0) send_beat(OP_TICK, 8'h00, 6'h00);
      gap_max = (cfg_q.idle_timeout_ticks > 4) ? 3 : cfg_q.idle_timeout_ticks - 1;
      for (k = 0; k < n_bytes && rx_mode_q == MODE_ACTIVE; k++) begin
         // a few ticks between bytes, short of the timeout
         if (cfg_q.idle_timeout_ticks > 1 && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, gap_max)) send_beat(OP_TICK, 8'($urandom), 6'($urandom));
         send_rx_byte();
         if (!clean && $urandom_range(0, 39) == 0) begin
            send_beat(OP_ABORT, 8'h00, 6'h00);
            return;
         end
         if (!clean && $urandom_range(0, 29) == 0) send_beat(OP_COLLECT, 8'h00, 6'h00);
      end
      // let the idle timeout close the frame
      while (rx_mode_q == MODE_ACTIVE && rcv_count_q != '0)
         send_beat(OP_TICK, 8'($urandom), 6'($urandom));
      if (!clean && $urandom_range(0, 9) == 0) send_rx_byte();
      send_beat(OP_COLLECT, 8'($urandom), 6'($urandom));
      if (!clean && $urandom_range(0, 9) == 0) send_beat(OP_COLLECT, 8'h00, 6'h00);
   endtask

   task automatic pick_settings();
      logic [8:0] len;
      logic [7:0] tmo;
      case ($urandom_range(0, 9))
         0:       len = 9'd1;
         1:       len = 9'd2;
         2:       len = 9'd0;
         3:       len = 9'($urandom_range(17, 40));
         default: len = 9'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 7))
         0:       tmo = 8'd0;
         1:       tmo = 8'd1;
         2:       tmo = 8'($urandom_range(9, 30));
         default: tmo = 8'($urandom_range(2, 8));
      endcase
      write_csr(CsrMaxFrameLen, len);
      write_csr(CsrIdleTimeout, {1'b0, tmo});
   endtask

   initial begin
      int unsigned phase_end;
      int          phase;

      // directed table: idle checks, arming, error flags, both ends of a frame
      directed_rows.push_back(beat_row(OP_COLLECT, 8'h00, 6'h00, 1'b1, RSP_IDLE));
      directed_rows.push_back(beat_row(OP_TICK,    8'h00, 6'h00, 1'b1, RSP_IDLE));
      directed_rows.push_back(beat_row(OP_BYTE,    8'hFF, 6'h3F, 1'b1, RSP_IDLE));
      directed_rows.push_back(beat_row(OpReservedHi, 8'hFF, 6'h3F, 1'b1, RSP_IDLE));
      directed_rows.push_back(beat_row(OP_ARM,     8'h00, 6'h00, 1'b1, RSP_ARMED));
      directed_rows.push_back(beat_row(OP_ARM,     8'h00, 6'h00, 1'b1, RSP_BUSY));
      directed_rows.push_back(beat_row(OP_TICK,    8'h00, 6'h00, 1'b1, RSP_BUSY));
      directed_rows.push_back(beat_row(OP_BYTE,    8'h00, 6'h02, 1'b0, RSP_IDLE));
      directed_rows.push_back(beat_row(OP_BYTE,    8'hFF, 6'h3F, 1'b0, RSP_IDLE));
      directed_rows.push_back(beat_row(OP_BYTE,    8'hA5, 6'h18, 1'b0, RSP_IDLE));
      directed_rows.push_back(beat_row(OP_COLLECT, 8'h00, 6'h00, 1'b1, RSP_BUSY));
      directed_rows.push_back(beat_row(OP_ABORT,   8'h00, 6'h00, 1'b1, RSP_IDLE));
      // two-byte frames, zero timeout
      directed_rows.push_back(csr_row(CsrMaxFrameLen, 9'd2));
      directed_rows.push_back(csr_row(CsrIdleTimeout, 9'd0));
      directed_rows.push_back(csr_row(CsrUnmapped, 9'h1FF));
      directed_rows.push_back(beat_row(OP_ARM,     8'h00, 6'h00, 1'b1, RSP_ARMED));
      directed_rows.push_back(beat_row(OP_BYTE,    8'h00, 6'h01, 1'b0, RSP_IDLE));
      directed_rows.push_back(beat_row(OP_BYTE,    8'h5A, 6'h04, 1'b0, RSP_IDLE));
      directed_rows.push_back(beat_row(OP_BYTE,    8'h11, 6'h00, 1'b0, RSP_IDLE));
      directed_rows.push_back(beat_row(OP_ARM,     8'h00, 6'h00, 1'b0, RSP_IDLE));
      directed_rows.push_back(beat_row(OP_COLLECT, 8'h00, 6'h00, 1'b0, RSP_IDLE));
      directed_rows.push_back(beat_row(OP_ARM,     8'h00, 6'h00, 1'b1, RSP_ARMED));
      directed_rows.push_back(beat_row(OP_BYTE,    8'h00, 6'h22, 1'b0, RSP_IDLE));
      directed_rows.push_back(beat_row(OP_TICK,    8'h00, 6'h00, 1'b0, RSP_IDLE));
      directed_rows.push_back(beat_row(OP_COLLECT, 8'h00, 6'h00, 1'b0, RSP_IDLE));
      // zero length arms nothing
      directed_rows.push_back(csr_row(CsrMaxFrameLen, 9'd0));
      directed_rows.push_back(beat_row(OP_ARM,     8'h00, 6'h00, 1'b1, RSP_ARM_EMPTY));
      directed_rows.push_back(beat_row(OP_ABORT,   8'h00, 6'h00, 1'b1, RSP_IDLE));
      directed_rows.push_back(csr_row(CsrMaxFrameLen, 9'h1FF));
      directed_rows.push_back(csr_row(CsrIdleTimeout, 9'd1));
      directed_rows.push_back(beat_row(OpReservedLo, 8'h3C, 6'h15, 1'b1, RSP_IDLE));

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR)
            write_csr(directed_rows[i].csr_idx, directed_rows[i].csr_val);
         else
            send_req(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
      end
      wait_drained();

      // random frames: receiver-heavy idling, then sender-heavy, then none
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 75 : 0;
         recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 37 : 0;
         phase_end = beats_counted + PhaseBeats;
         while (beats_counted < phase_end) begin
            pick_settings();
            repeat ($urandom_range(2, 5)) begin
               if ($urandom_range(0, 5) == 0)
                  send_beat(3'($urandom_range(0, 7)), 8'($urandom), 6'($urandom));
               else
                  run_frame($urandom_range(1, 12), 1'b0);
               if ($urandom_range(0, 3) == 0) wait_drained();
            end
         end
      end

      // longest frame, with the longest timeout set
      write_csr(CsrMaxFrameLen, 9'(FrameDepth));
      write_csr(CsrIdleTimeout, 9'd255);
      run_frame(FrameDepth, 1'b1);

      wait_drained();
      repeat (PipeLatency + 8) @(posedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
